@@ design/frgcd_pkg.sv @@
// Package for the fraction reducer: data width, sequencer states, datapath ops
// and the control/status structs shared by the sequencer and the top level.
// No dependencies.
`default_nettype none
package frgcd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SHIFT,
    ST_DIVN,
    ST_DIVD,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_GCD,
    OP_SHIFT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_NEXT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic in_stall;
  } ctrl_t;

  typedef struct packed {
    logic in_num_zero;
    logic in_den_zero;
    logic a_zero;
    logic k_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/frgcd_alu.sv @@
// Shared subtract/compare unit used by the gcd loop and both restoring divisions.
// Depends on frgcd_pkg for the data width.
`default_nettype none
module frgcd_alu (
  input  wire logic [frgcd_pkg::DATA_WIDTH:0] x_i,
  input  wire logic [frgcd_pkg::DATA_WIDTH:0] y_i,
  output logic      [frgcd_pkg::DATA_WIDTH:0] diff_o,
  output logic                              ge_o
);

  logic [frgcd_pkg::DATA_WIDTH+1:0] sub;

  assign sub    = {1'b0, x_i} - {1'b0, y_i};
  assign diff_o = sub[frgcd_pkg::DATA_WIDTH:0];
  assign ge_o   = ~sub[frgcd_pkg::DATA_WIDTH+1];

endmodule
`default_nettype wire

@@ design/frgcd_seq.sv @@
// Sequencer: load, binary gcd loop, gcd rescale, two restoring divisions, emit.
// Depends on frgcd_pkg for states, ops and the control/status structs.
`default_nettype none
module frgcd_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire frgcd_pkg::status_t status_i,
  output frgcd_pkg::ctrl_t        ctrl_o
);

  frgcd_pkg::state_e               state_q, state_d;
  logic [frgcd_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                            cnt_zero;

  assign cnt_zero = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frgcd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      frgcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_num_zero || status_i.in_den_zero) state_d = frgcd_pkg::ST_FIN;
          else state_d = frgcd_pkg::ST_GCD;
        end
      end
      frgcd_pkg::ST_GCD: begin
        if (status_i.a_zero) state_d = frgcd_pkg::ST_SHIFT;
      end
      frgcd_pkg::ST_SHIFT: begin
        if (status_i.k_zero) begin
          state_d = frgcd_pkg::ST_DIVN;
          cnt_d   = frgcd_pkg::CNT_W'(frgcd_pkg::DATA_WIDTH - 1);
        end
      end
      frgcd_pkg::ST_DIVN: begin
        if (cnt_zero) begin
          state_d = frgcd_pkg::ST_DIVD;
          cnt_d   = frgcd_pkg::CNT_W'(frgcd_pkg::DATA_WIDTH - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      frgcd_pkg::ST_DIVD: begin
        if (cnt_zero) state_d = frgcd_pkg::ST_FIN;
        else cnt_d = cnt_q - 1'b1;
      end
      frgcd_pkg::ST_FIN: begin
        if (status_i.out_free) state_d = frgcd_pkg::ST_IDLE;
      end
      default: state_d = frgcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.op       = frgcd_pkg::OP_NONE;
    ctrl_o.in_stall = 1'b1;
    unique case (state_q)
      frgcd_pkg::ST_IDLE: begin
        ctrl_o.in_stall = 1'b0;
        if (in_valid_i) ctrl_o.op = frgcd_pkg::OP_LOAD;
      end
      frgcd_pkg::ST_GCD: begin
        if (!status_i.a_zero) ctrl_o.op = frgcd_pkg::OP_GCD;
      end
      frgcd_pkg::ST_SHIFT: begin
        ctrl_o.op = status_i.k_zero ? frgcd_pkg::OP_DIV_INIT : frgcd_pkg::OP_SHIFT;
      end
      frgcd_pkg::ST_DIVN: begin
        ctrl_o.op = cnt_zero ? frgcd_pkg::OP_DIV_NEXT : frgcd_pkg::OP_DIV_STEP;
      end
      frgcd_pkg::ST_DIVD: begin
        ctrl_o.op = frgcd_pkg::OP_DIV_STEP;
      end
      frgcd_pkg::ST_FIN: begin
        if (status_i.out_free) ctrl_o.op = frgcd_pkg::OP_EMIT;
      end
      default: ctrl_o.op = frgcd_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ design/fraction_reducer_gcd.sv @@
// Top level of the fraction reducer: datapath registers, output register,
// sequencer and shared subtractor. Depends on frgcd_pkg, frgcd_alu, frgcd_seq.
//
//   channel | signals                                            | dir
//   --------+----------------------------------------------------+----
//   in      | in_valid_i, in_stall_o, numerator_i, denominator_i  | in
//   out     | out_valid_o, out_stall_i, reduced_numerator_o,      | out
//           | reduced_denominator_o, zero_denominator_error_o     |
//
// One item: a load, the binary gcd loop (one shift, swap or subtract per cycle)
// and its exit, shifts to restore the common power of two, the divider setup,
// a restoring division of the numerator, then of the denominator, and emit.
// Zero numerator or denominator skips straight to emit. Reset clears the
// sequencer and output valid. in_stall_o is high while busy; a result waits in
// the output register while out_stall_i is high.
`default_nettype none
module fraction_reducer_gcd (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [frgcd_pkg::DATA_WIDTH-1:0] numerator_i,
  input  wire logic signed [frgcd_pkg::DATA_WIDTH-1:0] denominator_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed      [frgcd_pkg::DATA_WIDTH-1:0] reduced_numerator_o,
  output logic signed      [frgcd_pkg::DATA_WIDTH-1:0] reduced_denominator_o,
  output logic                                        zero_denominator_error_o
);

  localparam int W = frgcd_pkg::DATA_WIDTH;

  frgcd_pkg::ctrl_t   ctrl;
  frgcd_pkg::status_t status;

  logic [W-1:0] a_q, a_d, b_q, b_d, an_q, an_d, ad_q, ad_d, r_q, r_d, dq_q, dq_d;
  logic [frgcd_pkg::CNT_W-1:0] k_q, k_d;
  logic negn_q, negn_d, negd_q, negd_d, err_q, err_d;
  logic out_valid_q, out_valid_d;
  logic [W-1:0] onum_q, onum_d, oden_q, oden_d;
  logic oerr_q, oerr_d;

  logic [W-1:0] mag_num, mag_den;
  logic [W:0]   alu_x, alu_y, alu_diff;
  logic         alu_ge;

  assign mag_num = numerator_i[W-1]   ? (W'(0) - numerator_i)   : numerator_i;
  assign mag_den = denominator_i[W-1] ? (W'(0) - denominator_i) : denominator_i;

  assign status.in_num_zero = (numerator_i == '0);
  assign status.in_den_zero = (denominator_i == '0);
  assign status.a_zero      = (a_q == '0);
  assign status.k_zero      = (k_q == '0);
  assign status.out_free    = !out_valid_q || !out_stall_i;

  frgcd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    if (ctrl.op == frgcd_pkg::OP_GCD) alu_x = {1'b0, a_q};
    else alu_x = {r_q, dq_q[W-1]};
    alu_y = {1'b0, b_q};
  end

  frgcd_alu u_alu (
    .x_i    (alu_x),
    .y_i    (alu_y),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    an_q   <= an_d;
    ad_q   <= ad_d;
    r_q    <= r_d;
    dq_q   <= dq_d;
    k_q    <= k_d;
    negn_q <= negn_d;
    negd_q <= negd_d;
    err_q  <= err_d;
    onum_q <= onum_d;
    oden_q <= oden_d;
    oerr_q <= oerr_d;
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    an_d   = an_q;
    ad_d   = ad_q;
    r_d    = r_q;
    dq_d   = dq_q;
    k_d    = k_q;
    negn_d = negn_q;
    negd_d = negd_q;
    err_d  = err_q;
    onum_d = onum_q;
    oden_d = oden_q;
    oerr_d = oerr_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (ctrl.op)
      frgcd_pkg::OP_LOAD: begin
        a_d    = mag_num;
        b_d    = mag_den;
        an_d   = mag_num;
        ad_d   = mag_den;
        k_d    = '0;
        negn_d = numerator_i[W-1];
        negd_d = denominator_i[W-1];
        err_d  = status.in_den_zero;
        dq_d   = W'(1);
        if (status.in_den_zero) begin
          an_d   = '0;
          dq_d   = '0;
          negn_d = 1'b0;
          negd_d = 1'b0;
        end else if (status.in_num_zero) begin
          an_d   = '0;
          negn_d = 1'b0;
          negd_d = 1'b0;
        end
      end
      frgcd_pkg::OP_GCD: begin
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!alu_ge) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          a_d = alu_diff[W-1:0] >> 1;
        end
      end
      frgcd_pkg::OP_SHIFT: begin
        b_d = b_q << 1;
        k_d = k_q - 1'b1;
      end
      frgcd_pkg::OP_DIV_INIT: begin
        r_d  = '0;
        dq_d = an_q;
      end
      frgcd_pkg::OP_DIV_STEP: begin
        r_d  = alu_ge ? alu_diff[W-1:0] : alu_x[W-1:0];
        dq_d = {dq_q[W-2:0], alu_ge};
      end
      frgcd_pkg::OP_DIV_NEXT: begin
        an_d = {dq_q[W-2:0], alu_ge};
        r_d  = '0;
        dq_d = ad_q;
      end
      frgcd_pkg::OP_EMIT: begin
        onum_d      = negn_q ? (W'(0) - an_q) : an_q;
        oden_d      = negd_q ? (W'(0) - dq_q) : dq_q;
        oerr_d      = err_q;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o               = ctrl.in_stall;
  assign out_valid_o              = out_valid_q;
  assign reduced_numerator_o      = onum_q;
  assign reduced_denominator_o    = oden_q;
  assign zero_denominator_error_o = oerr_q;

endmodule
`default_nettype wire

@@ verif/fraction_reducer_gcd_chk.sv @@
// Checker for the fraction reducer: watches both channels and predicts each
// result in lowest terms. Compares results in order and counts failures.
// Depends on frgcd_pkg for the data width.
module fraction_reducer_gcd_chk (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  input  logic                                        in_stall_i,
  input  logic signed [frgcd_pkg::DATA_WIDTH-1:0]     numerator_i,
  input  logic signed [frgcd_pkg::DATA_WIDTH-1:0]     denominator_i,
  input  logic                                        out_valid_i,
  input  logic                                        out_stall_i,
  input  logic signed [frgcd_pkg::DATA_WIDTH-1:0]     reduced_numerator_i,
  input  logic signed [frgcd_pkg::DATA_WIDTH-1:0]     reduced_denominator_i,
  input  logic                                        zero_denominator_error_i,
  output int                                          fail_count_o,
  output int                                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = frgcd_pkg::DATA_WIDTH;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    logic                err;
  } fraction_t;

  fraction_t lowest_terms_q[$];
  int        fails = 0;

  function automatic fraction_t reduce_fraction(logic [W-1:0] n, logic [W-1:0] d);
    fraction_t   r;
    logic [W-1:0] an, ad, a, b, t;
    r  = '0;
    an = n[W-1] ? -n : n;
    ad = d[W-1] ? -d : d;
    if (ad == '0) begin
      r.err = 1'b1;
    end else if (an == '0) begin
      r.den = 1;
    end else begin
      a = an;
      b = ad;
      while (b != '0) begin
        t = a % b;
        a = b;
        b = t;
      end
      r.num = n[W-1] ? -(an / a) : an / a;
      r.den = d[W-1] ? -(ad / a) : ad / a;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni) begin
      // results first: a result at this edge belongs to an older item
      if (out_valid_i && !out_stall_i) begin
        if (lowest_terms_q.size() == 0) begin
          fails = fails + 1;
          if (fails <= REPORT_MAX)
            $display("unexpected result %0d/%0d err %0b", reduced_numerator_i,
                     reduced_denominator_i, zero_denominator_error_i);
        end else begin
          want = lowest_terms_q.pop_front();
          if (want.num !== reduced_numerator_i || want.den !== reduced_denominator_i ||
              want.err !== zero_denominator_error_i) begin
            fails = fails + 1;
            if (fails <= REPORT_MAX)
              $display("mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                       want.num, want.den, want.err, reduced_numerator_i,
                       reduced_denominator_i, zero_denominator_error_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        lowest_terms_q.push_back(reduce_fraction(numerator_i, denominator_i));
    end
    fail_count_o <= fails;
    pending_o    <= lowest_terms_q.size();
  end

endmodule

@@ verif/fraction_reducer_gcd_tb.sv @@
// Testbench top for the fraction reducer: clock, reset, directed and random
// fractions with idle bursts on both channels, and the verdict.
// Depends on frgcd_pkg, fraction_reducer_gcd and fraction_reducer_gcd_chk.
module fraction_reducer_gcd_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = frgcd_pkg::DATA_WIDTH;
  localparam int CLK_PERIOD   = 10;
  localparam int ITEMS        = 1700;
  localparam int CALM_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_CYCLES = 2000000;
  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic signed [W-1:0] numerator   = '0;
  logic signed [W-1:0] denominator = '0;
  logic                out_stall   = 1'b0;
  logic                calm        = 1'b0;
  logic                no_idle     = 1'b0;
  int                  cycles      = 0;

  logic                in_stall;
  logic                out_valid;
  logic signed [W-1:0] reduced_numerator;
  logic signed [W-1:0] reduced_denominator;
  logic                zero_denominator_error;
  int                  fail_count;
  int                  pending;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  fraction_reducer_gcd dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid),
    .in_stall_o               (in_stall),
    .numerator_i              (numerator),
    .denominator_i            (denominator),
    .out_valid_o              (out_valid),
    .out_stall_i              (out_stall),
    .reduced_numerator_o      (reduced_numerator),
    .reduced_denominator_o    (reduced_denominator),
    .zero_denominator_error_o (zero_denominator_error)
  );

  fraction_reducer_gcd_chk chk (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid),
    .in_stall_i               (in_stall),
    .numerator_i              (numerator),
    .denominator_i            (denominator),
    .out_valid_i              (out_valid),
    .out_stall_i              (out_stall),
    .reduced_numerator_i      (reduced_numerator),
    .reduced_denominator_i    (reduced_denominator),
    .zero_denominator_error_i (zero_denominator_error),
    .fail_count_o             (fail_count),
    .pending_o                (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always begin
    if (!calm && !no_idle && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    out_stall <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  end

  task automatic offer_fraction(input logic signed [W-1:0] n, input logic signed [W-1:0] d);
    in_valid    <= 1'b1;
    numerator   <= n;
    denominator <= d;
    do @(posedge clk_i); while (in_stall);
    if (!calm && !no_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [W-1:0] extreme_value();
    case ($urandom_range(0, 5))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return 1;
      3:       return -1;
      4:       return MOST_NEG + 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [W-1:0] random_sign(logic signed [W-1:0] v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic pick_fraction(output logic signed [W-1:0] n, output logic signed [W-1:0] d);
    logic [W-1:0] g;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom;
        d = $urandom;
      end
      2, 3: begin
        // shared factor, so the divisor is large
        g = ($urandom >> $urandom_range(12, 31)) + 1;
        n = random_sign(g * ($urandom >> $urandom_range(18, 31)));
        d = random_sign(g * ($urandom >> $urandom_range(18, 31)));
      end
      4: begin
        // common powers of two
        n = random_sign(($urandom >> $urandom_range(8, 31)) << $urandom_range(0, 20));
        d = random_sign(($urandom >> $urandom_range(8, 31)) << $urandom_range(0, 20));
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          n = '0;
          d = $urandom;
        end else begin
          n = $urandom;
          d = '0;
        end
      end
      6: begin
        n = extreme_value();
        d = extreme_value();
      end
      default: begin
        n = int'($urandom_range(0, 2000)) - 1000;
        d = int'($urandom_range(0, 2000)) - 1000;
      end
    endcase
  endtask

  initial begin
    logic signed [W-1:0] n, d;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer_fraction(0, 5);
    offer_fraction(0, -7);
    offer_fraction(5, 0);
    offer_fraction(0, 0);
    offer_fraction(MOST_NEG, 0);
    offer_fraction(MOST_NEG, MOST_NEG);
    offer_fraction(MOST_NEG, 1);
    offer_fraction(MOST_NEG, -1);
    offer_fraction(MOST_NEG, 2);
    offer_fraction(1, MOST_NEG);
    offer_fraction(MOST_POS, MOST_POS);
    offer_fraction(MOST_POS, MOST_NEG);
    offer_fraction(MOST_POS, 1);
    offer_fraction(MOST_NEG + 1, MOST_POS);
    offer_fraction(6, -4);
    offer_fraction(-6, 4);
    offer_fraction(-6, -4);
    offer_fraction(12, 18);
    offer_fraction(1, 1);
    offer_fraction(-1, -1);
    offer_fraction(7, 13);
    offer_fraction(3 << 20, 1 << 25);
    offer_fraction(1024, -4096);
    offer_fraction(1 << 30, MOST_NEG);
    drain_results();

    for (int i = 0; i < ITEMS; i++) begin
      if (i % 150 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      if (i == ITEMS / 2) drain_results();
      if (i == ITEMS - CALM_ITEMS) calm <= 1'b1;
      pick_fraction(n, d);
      offer_fraction(n, d);
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
